>>> rtl/core/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared widths, coefficient tables and control types for the normalized
// hermite sequence core.
// ----------------------------------------------------------------------------
`default_nettype none

package hsc_pkg;

  localparam int MAX_ORDER   = 31;
  localparam int TABLE_DEPTH = MAX_ORDER + 1;
  localparam int ORDER_W     = 5;
  localparam int COEF_W      = 18;
  localparam int X_W         = 16;
  localparam int VAL_W       = 32;
  localparam int OPA_W       = 22;
  localparam int OPB_W       = 32;
  localparam int PROD_W      = OPA_W + OPB_W;
  localparam int ACC_W       = PROD_W + 1;
  localparam int RND_W       = ACC_W - 16;
  localparam int TABLE_BITS  = TABLE_DEPTH * COEF_W;
  localparam int DATA_W      = 40;

  localparam logic [ORDER_W-1:0] ORDER_LIMIT_RESET = 5'd8;
  localparam logic [VAL_W-1:0]   G0_VALUE          = 32'h0001_0000;

  // operand select for the shared multiplier
  localparam logic [1:0] MSEL_SCALE = 2'd0;
  localparam logic [1:0] MSEL_CROSS = 2'd1;
  localparam logic [1:0] MSEL_DAMP  = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       seed1;
    logic       mul_en;
    logic [1:0] msel;
    logic       round_en;
    logic       acc_load;
    logic       acc_sub;
    logic       sat_en;
    logic       advance;
  } hsc_ctrl_t;

  // restoring divide, elaboration only
  function automatic logic [63:0] const_div(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // floor square root, elaboration only
  function automatic logic [63:0] const_isqrt(input logic [63:0] val);
    logic [63:0] a;
    logic [63:0] r;
    logic [63:0] b;
    a = val;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // scale: 2/sqrt(n), damp: 2*sqrt((n-1)/n), both unsigned q2.16
  function automatic logic [TABLE_BITS-1:0] build_table(input logic damp);
    logic [TABLE_BITS-1:0] tbl;
    logic [63:0] num;
    logic [63:0] root;
    tbl = '0;
    for (int n = 1; n < TABLE_DEPTH; n++) begin
      num  = damp ? const_div(64'(n - 1) << 36, 64'(n)) : const_div(64'd1 << 36, 64'(n));
      root = (const_isqrt(num) + 64'd1) >> 1;
      tbl[n*COEF_W +: COEF_W] = root[COEF_W-1:0];
    end
    return tbl;
  endfunction

  localparam logic [TABLE_BITS-1:0] SCALE_TABLE = build_table(1'b0);
  localparam logic [TABLE_BITS-1:0] DAMP_TABLE  = build_table(1'b1);

endpackage

`default_nettype wire

>>> rtl/core/normalized_hermite_sequence_core.sv
// ----------------------------------------------------------------------------
// normalized_hermite_sequence_core
// Emits G_n(x) = H_n(x)/sqrt(n!) for n = 0 .. order_limit for each sample.
//
//   channel  dir  handshake              payload
//   s_*      in   s_tvalid / s_tready    tdata[15:0] sample_x
//   m_*      out  m_tvalid / m_tready    tdata[4:0] order_index,
//                                        tdata[36:5] hermite_value, tlast run_last
//   cfg_*    in   cfg_we                 cfg_wdata[4:0] order_limit
//
// G0 is loaded as one and G1 is seeded from the sample; every higher order
// steps through SCALE, ROUND, CROSS, DAMP, SUB and SAT before EMIT, sequencing
// the shared multiplier through three products plus round, subtract and saturate.
// Input is taken only when idle; a stalled result holds the whole sequence.
// Synchronous reset returns to idle and sets order_limit to 8.
// ----------------------------------------------------------------------------
`default_nettype none

module normalized_hermite_sequence_core
  import hsc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [X_W-1:0]     s_tdata,    // [15:0] sample_x
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [DATA_W-1:0]       m_tdata,    // [4:0] order_index, [36:5] hermite_value
  output logic                    m_tlast,
  input  wire logic               cfg_we,
  input  wire logic [ORDER_W-1:0] cfg_wdata
);

  logic [ORDER_W-1:0] order_limit;
  logic [ORDER_W-1:0] order;
  logic [VAL_W-1:0]   hermite_value;
  hsc_ctrl_t          ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_limit <= ORDER_LIMIT_RESET;
    end else if (cfg_we) begin
      order_limit <= cfg_wdata;
    end
  end

  hsc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .m_tready (m_tready),
    .limit    (order_limit),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .last     (m_tlast),
    .order    (order),
    .ctrl     (ctrl)
  );

  hsc_dp u_dp (
    .clk           (clk),
    .ctrl          (ctrl),
    .order         (order),
    .sample_x      (s_tdata),
    .hermite_value (hermite_value)
  );

  assign m_tdata = {{(DATA_W-VAL_W-ORDER_W){1'b0}}, hermite_value, order};

endmodule

`default_nettype wire

>>> rtl/core/hsc_mul.sv
// ----------------------------------------------------------------------------
// hsc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_mul
  import hsc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [OPA_W-1:0]  a,
  input  wire logic signed [OPB_W-1:0]  b,
  output logic signed [PROD_W-1:0]      prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/hsc_dp.sv
// ----------------------------------------------------------------------------
// hsc_dp
// Recurrence datapath: sample, history, accumulator and result register
// around the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_dp
  import hsc_pkg::*;
(
  input  wire logic                 clk,
  input  wire hsc_ctrl_t            ctrl,
  input  wire logic [ORDER_W-1:0]   order,
  input  wire logic [X_W-1:0]       sample_x,
  output logic [VAL_W-1:0]          hermite_value
);

  logic signed [X_W-1:0]    x;
  logic signed [VAL_W-1:0]  prev;
  logic signed [VAL_W-1:0]  older;
  logic signed [OPA_W-1:0]  p16;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PROD_W-1:0] prod;
  logic signed [OPA_W-1:0]  mul_a;
  logic signed [OPB_W-1:0]  mul_b;
  logic [COEF_W-1:0]        scale_coef;
  logic [COEF_W-1:0]        damp_coef;
  logic signed [34:0]       p_rounded;
  logic signed [ACC_W-1:0]  acc_rounded;
  logic signed [RND_W-1:0]  g_wide;
  logic [VAL_W-1:0]         g_sat;

  assign scale_coef = SCALE_TABLE[int'(order)*COEF_W +: COEF_W];
  assign damp_coef  = DAMP_TABLE[int'(order)*COEF_W +: COEF_W];

  always_comb begin
    unique case (ctrl.msel)
      MSEL_SCALE: begin
        mul_a = signed'({{(OPA_W-COEF_W){1'b0}}, scale_coef});
        mul_b = OPB_W'(x);
      end
      MSEL_CROSS: begin
        mul_a = p16;
        mul_b = prev;
      end
      MSEL_DAMP: begin
        mul_a = signed'({{(OPA_W-COEF_W){1'b0}}, damp_coef});
        mul_b = older;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  hsc_mul u_mul (
    .clk  (clk),
    .en   (ctrl.mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // scale product is q.28, round to q.16
  assign p_rounded = 35'(prod[33:0]) + 35'sd2048;

  assign acc_rounded = acc + ACC_W'(32768);
  assign g_wide      = acc_rounded[ACC_W-1:16];

  always_comb begin
    if (!g_wide[RND_W-1] && (|g_wide[RND_W-2:VAL_W-1])) begin
      g_sat = 32'h7FFF_FFFF;
    end else if (g_wide[RND_W-1] && !(&g_wide[RND_W-2:VAL_W-1])) begin
      g_sat = 32'h8000_0000;
    end else begin
      g_sat = g_wide[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      x             <= sample_x;
      hermite_value <= G0_VALUE;
    end
    if (ctrl.round_en) begin
      p16 <= p_rounded[33:12];
    end
    if (ctrl.acc_load) begin
      acc <= ACC_W'(prod);
    end else if (ctrl.acc_sub) begin
      acc <= acc - ACC_W'(prod);
    end
    if (ctrl.advance) begin
      older <= prev;
      prev  <= hermite_value;
    end
    if (ctrl.seed1) begin
      hermite_value <= {{(VAL_W-X_W-5){x[X_W-1]}}, x, 5'b0};
    end else if (ctrl.sat_en) begin
      hermite_value <= g_sat;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/hsc_seq.sv
// ----------------------------------------------------------------------------
// hsc_seq
// Sequencer: walks the orders of one sample and steps the shared multiplier
// through the three products of each recurrence step.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_seq
  import hsc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  input  wire logic               m_tready,
  input  wire logic [ORDER_W-1:0] limit,
  output logic                    s_tready,
  output logic                    m_tvalid,
  output logic                    last,
  output logic [ORDER_W-1:0]      order,
  output hsc_ctrl_t               ctrl
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCALE = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_CROSS = 3'd3;
  localparam logic [2:0] ST_DAMP  = 3'd4;
  localparam logic [2:0] ST_SUB   = 3'd5;
  localparam logic [2:0] ST_SAT   = 3'd6;
  localparam logic [2:0] ST_EMIT  = 3'd7;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [ORDER_W-1:0] order_next;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_EMIT);
  assign last     = (order == limit);

  always_comb begin
    state_next = state;
    order_next = order;
    ctrl       = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          ctrl.capture = 1'b1;
          order_next   = '0;
          state_next   = ST_EMIT;
        end
      end
      ST_SCALE: begin
        ctrl.mul_en = 1'b1;
        ctrl.msel   = MSEL_SCALE;
        state_next  = ST_ROUND;
      end
      ST_ROUND: begin
        ctrl.round_en = 1'b1;
        state_next    = ST_CROSS;
      end
      ST_CROSS: begin
        ctrl.mul_en = 1'b1;
        ctrl.msel   = MSEL_CROSS;
        state_next  = ST_DAMP;
      end
      ST_DAMP: begin
        ctrl.mul_en   = 1'b1;
        ctrl.msel     = MSEL_DAMP;
        ctrl.acc_load = 1'b1;
        state_next    = ST_SUB;
      end
      ST_SUB: begin
        ctrl.acc_sub = 1'b1;
        state_next   = ST_SAT;
      end
      ST_SAT: begin
        ctrl.sat_en = 1'b1;
        state_next  = ST_EMIT;
      end
      ST_EMIT: begin
        if (m_tready) begin
          ctrl.advance = 1'b1;
          if (last) begin
            state_next = ST_IDLE;
          end else begin
            order_next = order + 1'b1;
            // first order is seeded straight from the sample
            if (order == '0) begin
              ctrl.seed1 = 1'b1;
            end else begin
              state_next = ST_SCALE;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      order <= '0;
    end else begin
      state <= state_next;
      order <= order_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/hsc_checker.sv
// ----------------------------------------------------------------------------
// hsc_checker
// Port-level checks on the sequence core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_checker
  import hsc_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              s_tvalid,
  input wire logic              s_tready,
  input wire logic              m_tvalid,
  input wire logic              m_tready,
  input wire logic [DATA_W-1:0] m_tdata,
  input wire logic              m_tlast
);

  // never takes a sample while a word is on offer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while output valid");

  // a run opens with order zero on the next cycle
  a_first: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (m_tvalid && m_tdata[4:0] == '0))
    else $error("run did not start with order zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output word changed");

  // the last word frees the input, any other keeps it closed
  a_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("not idle after last word");

  a_mid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> !s_tready)
    else $error("input opened mid run");

endmodule

bind normalized_hermite_sequence_core hsc_checker u_hsc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the normalized hermite sequence core against a predictor of its
// recurrence. Samples and order-limit changes come from a queue; each accepted
// sample predicts its whole run of words, which the monitor compares in order
// while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import hsc_pkg::*;

  localparam int     CYCLE_LIMIT = 400000;
  localparam longint VALUE_MAX   = 64'sd2147483647;
  localparam longint VALUE_MIN   = -64'sd2147483648;

  typedef enum logic [1:0] {STIM_SAMPLE, STIM_LIMIT, STIM_DRAIN} stim_kind_t;

  typedef struct {
    stim_kind_t kind;
    logic [15:0] value;
    logic calm;
  } stim_entry_t;

  typedef struct packed {
    logic [ORDER_W-1:0] order;
    logic [31:0] value;
    logic last;
  } hermite_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [X_W-1:0] s_tdata = '0;      // [15:0] sample_x
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;        // [4:0] order_index, [36:5] hermite_value
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [ORDER_W-1:0] cfg_wdata = '0;

  stim_entry_t stim_queue[$];
  hermite_word_t words_pending[$];
  logic [COEF_W-1:0] scale_coef[TABLE_DEPTH];
  logic [COEF_W-1:0] damp_coef[TABLE_DEPTH];
  int order_limit_now = int'(ORDER_LIMIT_RESET);
  int words_due = 0;
  int words_seen = 0;
  int error_count = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int recv_stall = 0;
  int recv_count = 0;

  normalized_hermite_sequence_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic longint unsigned floor_root(input longint unsigned a);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > a) b >>= 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // g0 = 1, g1 = 2x, then the scaled three-term recurrence with saturation
  function automatic void predict_hermite_run(input logic [15:0] raw);
    longint x;
    longint prev;
    longint older;
    longint g;
    longint p;
    longint p16;
    longint acc;
    hermite_word_t w;
    x = longint'(signed'(raw));
    prev = 0;
    older = 0;
    for (int n = 0; n <= order_limit_now; n++) begin
      if (n == 0) begin
        g = 65536;
      end else if (n == 1) begin
        g = x * 32;
      end else begin
        p = longint'(scale_coef[n]) * x;
        p16 = (p + 2048) >>> 12;
        acc = p16 * prev - longint'(damp_coef[n]) * older;
        g = (acc + 32768) >>> 16;
        if (g > VALUE_MAX) g = VALUE_MAX;
        else if (g < VALUE_MIN) g = VALUE_MIN;
      end
      older = prev;
      prev = g;
      w.order = n[ORDER_W-1:0];
      w.value = g[31:0];
      w.last = (n == order_limit_now);
      words_pending.push_back(w);
    end
    words_due += order_limit_now + 1;
  endfunction

  task automatic add_sample(input logic [15:0] value, input logic calm);
    stim_queue.push_back('{STIM_SAMPLE, value, calm});
  endtask

  task automatic add_limit(input int limit);
    stim_queue.push_back('{STIM_LIMIT, 16'(limit), 1'b0});
  endtask

  // sample and order-limit driver
  always @(posedge clk) begin
    logic next_valid;
    logic next_we;
    stim_entry_t head;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      cfg_we <= 1'b0;
      cfg_wdata <= '0;
      send_gap = 0;
    end else begin
      next_valid = s_tvalid;
      next_we = 1'b0;
      if (s_tvalid && s_tready) begin
        predict_hermite_run(s_tdata);
        next_valid = 1'b0;
      end
      if (!next_valid && stim_queue.size() > 0) begin
        head = stim_queue[0];
        if (head.kind == STIM_SAMPLE) begin
          if (send_gap > 0) begin
            send_gap--;
          end else begin
            next_valid = 1'b1;
            s_tdata <= head.value;
            void'(stim_queue.pop_front());
            send_gap = head.calm ? 0 : $urandom_range(0, 9);
          end
        end else if (words_seen == words_due) begin
          // register writes and pauses only once the whole run has drained
          if (head.kind == STIM_LIMIT) begin
            next_we = 1'b1;
            cfg_wdata <= head.value[ORDER_W-1:0];
            order_limit_now = int'(head.value[ORDER_W-1:0]);
          end
          void'(stim_queue.pop_front());
        end
      end
      s_tvalid <= next_valid;
      cfg_we <= next_we;
    end
  end

  // result monitor
  always @(posedge clk) begin
    hermite_word_t want;
    if (rst) begin
      m_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        words_seen <= words_seen + 1;
        if (words_pending.size() == 0) begin
          $error("unexpected word: order_index %0d", m_tdata[4:0]);
          error_count++;
        end else begin
          want = words_pending.pop_front();
          if (m_tdata[4:0] !== want.order) begin
            $error("order_index: expected %0d, got %0d", want.order, m_tdata[4:0]);
            error_count++;
          end
          if (m_tdata[36:5] !== want.value) begin
            $error("hermite_value: expected %0d, got %0d",
                   $signed(want.value), $signed(m_tdata[36:5]));
            error_count++;
          end
          if (m_tlast !== want.last) begin
            $error("run_last: expected %0d, got %0d", want.last, m_tlast);
            error_count++;
          end
        end
        recv_count++;
        // every third stretch of fifty words runs without stalls
        recv_stall = ((recv_count / 50) % 3 == 0) ? 0 : $urandom_range(0, 9);
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      m_tready <= (recv_stall == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    int sent;
    int phase;
    int pick;
    int run_len;
    logic [15:0] x;
    for (int n = 0; n < TABLE_DEPTH; n++) begin
      if (n == 0) begin
        scale_coef[n] = '0;
        damp_coef[n] = '0;
      end else begin
        scale_coef[n] = COEF_W'((floor_root((64'd1 << 36) / n) + 1) >> 1);
        damp_coef[n] = COEF_W'((floor_root(((64'd1 << 36) * (n - 1)) / n) + 1) >> 1);
      end
    end

    // directed: reset limit first, then the deepest, zero and single order
    add_sample(16'h0000, 1'b0);
    add_sample(16'h0001, 1'b0);
    add_sample(16'hFFFF, 1'b1);
    add_sample(16'h7FFF, 1'b1);
    add_sample(16'h8000, 1'b0);
    add_sample(16'h1000, 1'b0);
    add_sample(16'hF000, 1'b0);
    add_sample(16'h5555, 1'b0);
    add_sample(16'hAAAA, 1'b0);
    add_limit(MAX_ORDER);
    // large arguments drive the history into saturation
    add_sample(16'h7FFF, 1'b0);
    add_sample(16'h8000, 1'b1);
    add_sample(16'h2000, 1'b0);
    add_sample(16'h04D2, 1'b0);
    add_limit(0);
    add_sample(16'h7FFF, 1'b0);
    add_sample(16'h8000, 1'b1);
    add_limit(1);
    add_sample(16'h0064, 1'b0);
    add_sample(16'hFF9C, 1'b0);

    sent = 0;
    phase = 0;
    while (sent < 203) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) add_limit(0);
      else if (pick == 1) add_limit(MAX_ORDER);
      else if (pick == 2) add_limit(1);
      else add_limit($urandom_range(2, 10));
      run_len = $urandom_range(8, 20);
      for (int i = 0; i < run_len; i++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          case ($urandom_range(0, 4))
            0: x = 16'h7FFF;
            1: x = 16'h8000;
            2: x = 16'h0000;
            3: x = 16'h0001;
            default: x = 16'hFFFF;
          endcase
        end else if (pick <= 4) begin
          x = 16'($signed($urandom_range(0, 16383)) - 8192);
        end else begin
          x = 16'($urandom);
        end
        add_sample(x, phase % 4 == 1);
        sent++;
        if (phase == 3 && i == 4) stim_queue.push_back('{STIM_DRAIN, 16'h0000, 1'b0});
      end
      phase++;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (!(stim_queue.size() == 0 && !s_tvalid && words_seen == words_due));
    repeat (40) @(posedge clk);
    if (words_pending.size() != 0) begin
      $error("%0d words never arrived", words_pending.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
